### hw/rtl/mer_pkg.sv
// Shared types and constants of the midpoint ellipse rasterizer.
// No dependencies; used by the top level of the block.
package mer_pkg;

  // Default sizes of the top level
  localparam int RADIUS_BITS_DEF = 11;
  localparam int COORD_BITS_DEF  = 16;
  localparam int DIM_BITS_DEF    = 12;

  // Fixed field widths
  localparam int CFG_W   = 13;
  localparam int PIX_W   = 12;
  localparam int COLOR_W = 24;

  // Register indexes and reset values
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  // Item commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Hard ceiling on pixel coordinates
  localparam int PIX_LIMIT = 4096;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_MAJ,
    ST_SQ_MIN,
    ST_D0,
    ST_D1,
    ST_E0,
    ST_E1,
    ST_E2,
    ST_E3,
    ST_E4,
    ST_E5,
    ST_E6,
    ST_SCAN,
    ST_UPD,
    ST_U1,
    ST_U2,
    ST_U3,
    ST_U4,
    ST_U5,
    ST_FLUSH
  } state_t;

endpackage

### hw/rtl/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse and circle rasterizer, top level; uses mer_pkg and mer_mul.
// Start item: squares both radii and sets the decision term, plus a second setup state for an
// ellipse, which enters the second region at once when its minor radius is zero.
// Step item: scans candidates (8 circle, 4 ellipse), updates, may enter the second region, flushes.
// One item at a time; the shared multiplier and a stalled pixel port set the rate.
// Reset (synchronous, rst high): idle, image 640 by 480, no pixel pending.
module midpoint_ellipse_rasterizer
  import mer_pkg::*;
#(
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int DIM_BITS    = mer_pkg::DIM_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic                             cfg_index,
  input  logic [mer_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd,
  input  logic signed [COORD_BITS-1:0]     center_x,
  input  logic signed [COORD_BITS-1:0]     center_y,
  input  logic [RADIUS_BITS-1:0]           radius_x,
  input  logic [RADIUS_BITS-1:0]           radius_y,
  input  logic [mer_pkg::COLOR_W-1:0]      paint_color,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mer_pkg::PIX_W-1:0]        pixel_x,
  output logic [mer_pkg::PIX_W-1:0]        pixel_y,
  output logic [mer_pkg::COLOR_W-1:0]      pixel_color,
  output logic                             last_of_step,
  output logic                             shape_done
);

  localparam int RB  = RADIUS_BITS;
  localparam int QW  = 2 * RB;
  localparam int SW  = RB + 2;
  localparam int MA  = 3 * RB + 3;
  localparam int MB  = RB + 5;
  localparam int DW  = MA + MB;
  localparam int LW  = CFG_W + 1;
  localparam int CW0 = (COORD_BITS > RB + 2) ? COORD_BITS : RB + 2;
  localparam int CW  = ((CW0 > LW) ? CW0 : LW) + 1;
  localparam logic [LW-1:0] DIM_LIM = (DIM_BITS >= 12) ? LW'(PIX_LIMIT) : LW'(1 << DIM_BITS);

  state_t state, state_next;

  logic [CFG_W-1:0] image_width, image_height;
  logic             active, circle_mode, axes_swapped, second_region, in_step, done_f;
  logic signed [COORD_BITS-1:0] origin_x, origin_y;
  logic signed [SW-1:0]         step_x, step_y;
  logic [RB-1:0]    major_r, minor_r;
  logic [QW-1:0]    major_sq, minor_sq;
  logic signed [DW-1:0] decision, acc;
  logic [COLOR_W-1:0]   shape_color;
  logic [2:0]       cand;
  logic             held_valid;
  logic [PIX_W-1:0] held_x, held_y;

  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [DW-1:0] prod;

  mer_mul #(.AW(MA), .BW(MB)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Operand forms used by the sequencer
  logic signed [MA-1:0] a_major_sq, a_minor_sq, a_prod, a_major_r;
  logic signed [MB-1:0] b_minor_r, b_x8p12, b_x8p8, b_y8m8, b_y8m12, b_tx, b_ym, b_x, b_y;
  assign a_major_sq = MA'($signed({1'b0, major_sq}));
  assign a_minor_sq = MA'($signed({1'b0, minor_sq}));
  assign a_prod     = MA'(prod);
  assign a_major_r  = MA'($signed({1'b0, major_r}));
  assign b_minor_r  = MB'($signed({1'b0, minor_r}));
  assign b_x        = MB'(step_x);
  assign b_y        = MB'(step_y);
  assign b_x8p12    = (b_x <<< 3) + MB'(12);
  assign b_x8p8     = (b_x <<< 3) + MB'(8);
  assign b_y8m8     = (b_y <<< 3) - MB'(8);
  assign b_y8m12    = (b_y <<< 3) - MB'(12);
  assign b_tx       = (b_x <<< 1) + MB'(1);
  assign b_ym       = b_y - MB'(1);

  // Candidate pixel of the current scan slot
  logic                 swap_c, neg_x, neg_y, last_cand, in_bounds;
  logic signed [SW-1:0] ca, cb, dx, dy;
  logic signed [CW-1:0] px, py;
  logic [LW-1:0]        lim_w, lim_h;
  assign swap_c    = circle_mode ? cand[2] : axes_swapped;
  assign ca        = swap_c ? step_y : step_x;
  assign cb        = swap_c ? step_x : step_y;
  assign neg_x     = cand[1];
  assign neg_y     = cand[1] ^ cand[0];
  assign dx        = neg_x ? -ca : ca;
  assign dy        = neg_y ? -cb : cb;
  assign px        = CW'(origin_x) + CW'(dx);
  assign py        = CW'(origin_y) + CW'(dy);
  assign lim_w     = (LW'(image_width) > DIM_LIM) ? DIM_LIM : LW'(image_width);
  assign lim_h     = (LW'(image_height) > DIM_LIM) ? DIM_LIM : LW'(image_height);
  assign in_bounds = !px[CW-1] && !py[CW-1] &&
                     (px < $signed({1'b0, CW'(lim_w)})) && (py < $signed({1'b0, CW'(lim_h)}));
  assign last_cand = circle_mode ? (cand == 3'd7) : (cand == 3'd3);

  // Handshake terms
  logic in_acc, push_ok, scan_push, flush_push, scan_wait;
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign push_ok  = !out_valid || !out_stall;
  // A scan slot waits when it must push the held pixel and the port is busy
  assign scan_wait = in_bounds && held_valid && !push_ok;

  // Step arithmetic
  logic signed [DW-1:0] circ_next, r1_next, r2_next;
  logic signed [SW-1:0] circ_y;
  assign circ_next = decision[DW-1] ?
      decision + (DW'(step_x) <<< 3) + DW'(12) :
      decision + ((DW'(step_x) - DW'(step_y)) <<< 3) + DW'(20);
  assign circ_y    = decision[DW-1] ? step_y : step_y - SW'(1);
  assign r1_next   = decision[DW-1] ? decision + acc : decision + acc - prod;
  assign r2_next   = (decision > DW'(0)) ? decision - acc : decision + prod - acc;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && cmd == CMD_START) state_next = ST_SQ_MAJ;
        else if (in_acc && active) state_next = ST_SCAN;
      end
      ST_SQ_MAJ: state_next = ST_SQ_MIN;
      ST_SQ_MIN: state_next = ST_D0;
      ST_D0:     state_next = circle_mode ? ST_IDLE : ST_D1;
      ST_D1:     state_next = (minor_r == '0) ? ST_E0 : ST_IDLE;
      ST_E0:     state_next = ST_E1;
      ST_E1:     state_next = ST_E2;
      ST_E2:     state_next = ST_E3;
      ST_E3:     state_next = ST_E4;
      ST_E4:     state_next = ST_E5;
      ST_E5:     state_next = ST_E6;
      ST_E6:     state_next = in_step ? ST_FLUSH : ST_IDLE;
      ST_SCAN: begin
        if (last_cand && !scan_wait) state_next = ST_UPD;
      end
      ST_UPD:    state_next = circle_mode ? ST_FLUSH : ST_U1;
      ST_U1:     state_next = ST_U2;
      ST_U2:     state_next = second_region ? ST_FLUSH : ST_U3;
      ST_U3:     state_next = ST_U4;
      ST_U4:     state_next = ST_U5;
      ST_U5:     state_next = (acc < prod) ? ST_FLUSH : ST_E0;
      ST_FLUSH: begin
        if (!held_valid || push_ok) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: multiplier operands and pixel pushes
  always_comb begin
    mul_a      = a_major_sq;
    mul_b      = b_minor_r;
    scan_push  = 1'b0;
    flush_push = 1'b0;
    case (state)
      ST_SQ_MAJ: begin
        mul_a = a_major_r;
        mul_b = MB'($signed({1'b0, major_r}));
      end
      ST_SQ_MIN: begin
        mul_a = MA'($signed({1'b0, minor_r}));
        mul_b = b_minor_r;
      end
      ST_D0: begin
        mul_a = MA'($signed({1'b0, major_sq}));
        mul_b = b_minor_r;
      end
      ST_E0: begin
        mul_a = a_minor_sq;
        mul_b = b_tx;
      end
      ST_E1: begin
        mul_a = a_prod;
        mul_b = b_tx;
      end
      ST_E2: begin
        mul_a = a_major_sq;
        mul_b = b_ym;
      end
      ST_E3: begin
        mul_a = a_prod;
        mul_b = b_ym;
      end
      ST_E4: begin
        mul_a = a_major_sq;
        mul_b = b_minor_r;
      end
      ST_E5: begin
        mul_a = a_prod;
        mul_b = b_minor_r;
      end
      ST_SCAN: begin
        scan_push = in_bounds && held_valid && push_ok;
      end
      ST_UPD: begin
        mul_a = second_region ? a_major_sq : a_minor_sq;
        mul_b = second_region ? b_y8m12 : b_x8p12;
      end
      ST_U1: begin
        mul_a = second_region ? a_minor_sq : a_major_sq;
        mul_b = second_region ? b_x8p8 : b_y8m8;
      end
      ST_U3: begin
        mul_a = a_minor_sq;
        mul_b = b_x;
      end
      ST_U4: begin
        mul_a = a_major_sq;
        mul_b = b_y;
      end
      ST_FLUSH: begin
        flush_push = held_valid && push_ok;
      end
      default: begin
        mul_a = a_major_sq;
        mul_b = b_minor_r;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      image_width   <= WIDTH_RESET;
      image_height  <= HEIGHT_RESET;
      active        <= 1'b0;
      circle_mode   <= 1'b0;
      axes_swapped  <= 1'b0;
      second_region <= 1'b0;
      in_step       <= 1'b0;
      done_f        <= 1'b0;
      held_valid    <= 1'b0;
      out_valid     <= 1'b0;
      cand          <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        if (cfg_index == CFG_IMAGE_WIDTH) image_width <= cfg_data;
        else image_height <= cfg_data;
      end
      // Load a pushed pixel, drop the output item once taken
      if (scan_push || flush_push) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_acc && cmd == CMD_START) begin
            active        <= 1'b1;
            second_region <= 1'b0;
            in_step       <= 1'b0;
            circle_mode   <= (radius_x == radius_y);
            axes_swapped  <= (radius_y > radius_x);
          end else if (in_acc && active) begin
            in_step    <= 1'b1;
            done_f     <= 1'b0;
            held_valid <= 1'b0;
            cand       <= '0;
          end
        end
        ST_E6: second_region <= 1'b1;
        ST_SCAN: begin
          if (in_bounds && !held_valid) held_valid <= 1'b1;
          if (!scan_wait) cand <= cand + 3'd1;
        end
        ST_UPD: begin
          if (circle_mode) done_f <= (step_x + SW'(1)) > circ_y;
        end
        ST_U2: begin
          if (second_region) done_f <= (step_y - SW'(1)) < SW'(0);
        end
        ST_FLUSH: begin
          if (!held_valid || push_ok) begin
            if (done_f) active <= 1'b0;
            held_valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc && cmd == CMD_START) begin
          origin_x    <= center_x;
          origin_y    <= center_y;
          shape_color <= paint_color;
          step_x      <= '0;
          if (radius_y > radius_x) begin
            major_r <= radius_y;
            minor_r <= radius_x;
            step_y  <= SW'($signed({1'b0, radius_x}));
          end else begin
            major_r <= radius_x;
            minor_r <= radius_y;
            step_y  <= SW'($signed({1'b0, radius_y}));
          end
        end
      end
      ST_SQ_MIN: major_sq <= QW'(prod);
      ST_D0: begin
        minor_sq <= QW'(prod);
        decision <= DW'(5) - (DW'($signed({1'b0, major_r})) <<< 2);
      end
      ST_D1: begin
        decision <= (DW'($signed({1'b0, minor_sq})) <<< 2) - (prod <<< 2) +
                    DW'($signed({1'b0, major_sq}));
      end
      ST_E2: acc <= prod;
      ST_E4: acc <= acc + (prod <<< 2);
      ST_E6: decision <= acc - (prod <<< 2);
      ST_SCAN: begin
        // Hold an in-bounds pixel until the next one or the flush
        if (in_bounds && (!held_valid || push_ok)) begin
          held_x <= PIX_W'(px);
          held_y <= PIX_W'(py);
        end
        if (scan_push) begin
          pixel_x      <= held_x;
          pixel_y      <= held_y;
          pixel_color  <= shape_color;
          last_of_step <= 1'b0;
          shape_done   <= 1'b0;
        end
      end
      ST_UPD: begin
        if (circle_mode) begin
          decision <= circ_next;
          step_x   <= step_x + SW'(1);
          step_y   <= circ_y;
        end
      end
      ST_U1: acc <= prod;
      ST_U2: begin
        if (second_region) begin
          decision <= r2_next;
          if (!(decision > DW'(0))) step_x <= step_x + SW'(1);
          step_y <= step_y - SW'(1);
        end else begin
          decision <= r1_next;
          step_x   <= step_x + SW'(1);
          if (!decision[DW-1]) step_y <= step_y - SW'(1);
        end
      end
      ST_U4: acc <= prod;
      ST_FLUSH: begin
        if (flush_push) begin
          pixel_x      <= held_x;
          pixel_y      <= held_y;
          pixel_color  <= shape_color;
          last_of_step <= 1'b1;
          shape_done   <= done_f;
        end
      end
      default: begin
      end
    endcase
  end

  // A finished shape is flagged only on the closing pixel of a step
  assert property (@(posedge clk) disable iff (rst)
    out_valid && shape_done |-> last_of_step)
    else $error("shape_done without last_of_step");

  // No pixel is held across items
  assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !held_valid)
    else $error("pixel held while idle");

  // The second region belongs to the ellipse only
  assert property (@(posedge clk) disable iff (rst)
    second_region |-> !circle_mode)
    else $error("second region in circle mode");

  // An accepted step on an active shape occupies the block
  assert property (@(posedge clk) disable iff (rst)
    in_acc && cmd == CMD_STEP && active |=> in_stall)
    else $error("step item did not start work");

endmodule

### hw/rtl/mer_mul.sv
// Registered signed multiplier shared by every product of the rasterizer.
// Depends on nothing; one result per cycle, and the product is registered.
module mer_mul #(
  parameter int AW = 36,
  parameter int BW = 16
) (
  input  logic                     clk,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);

  // Register the product
  always_ff @(posedge clk) begin
    p <= (AW+BW)'(a) * (AW+BW)'(b);
  end

endmodule
